// ===== rtl/nnq_pkg.sv =====
package nnq_pkg;

  localparam int FREQ_W = 24;          // unsigned Q16.8 Hz
  localparam int IDX_IN_W = 7;         // entry_index / note_index width
  localparam int SIZE_W = 8;           // table_size register width
  localparam int NOTE_COUNT_DEF = 128;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 8'd128;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // control flags that ride along the search chain with each item
  typedef struct packed {
    logic act;   // an item sits in this stage
    logic srch;  // the search is still narrowing
  } nnq_flags_t;

endpackage

// ===== rtl/nearest_note_quantizer_top.sv =====
// Channel   Handshake              Payload
// --------  ---------------------  -----------------------------------------------
// item in   start_i, busy_o        mode_i, entry_index_i, entry_freq_i, query_freq_i
// result    done_o (strobe)        note_index_o
// config    cfg_valid_i/ready_o    cfg_data_i (table_size)
//
// A write item lands in the table at the accept edge; busy stays low.
// A query item keeps busy high through the search chain and the product test;
// done_o pulses in the cycle busy drops, so a new query is taken only once the
// last one is through. The search chain has one cell per halving, one table read each.
// Reset clears control flags and sets table_size to 128; table contents stay
// undefined until written. The receiver cannot stall: each result shows once.
module nearest_note_quantizer_top #(
  parameter int NOTE_COUNT = nnq_pkg::NOTE_COUNT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         mode_i,
  input  logic [nnq_pkg::IDX_IN_W-1:0] entry_index_i,
  input  logic [nnq_pkg::FREQ_W-1:0]   entry_freq_i,
  input  logic [nnq_pkg::FREQ_W-1:0]   query_freq_i,
  output logic                         done_o,
  output logic [nnq_pkg::IDX_IN_W-1:0] note_index_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [nnq_pkg::SIZE_W-1:0]   cfg_data_i
);

  localparam int IDX_W = $clog2(NOTE_COUNT);
  localparam int NW    = IDX_W + 1;
  localparam int STEPS = $clog2(NOTE_COUNT);   // halvings over size-1 candidates

  // configuration
  logic [nnq_pkg::SIZE_W-1:0] table_size_q;
  logic [NW-1:0]              n_use;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= nnq_pkg::SIZE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      table_size_q <= cfg_data_i;
    end
  end

  // clamp the size in use to 2..NOTE_COUNT
  always_comb begin
    if (32'(table_size_q) < 32'd2) begin
      n_use = NW'(2);
    end else if (32'(table_size_q) > 32'(NOTE_COUNT)) begin
      n_use = NW'(NOTE_COUNT);
    end else begin
      n_use = NW'(table_size_q);
    end
  end

  // accept and hold
  logic accept, wr_fire, q_fire, idx_ok;
  logic busy_q;
  logic fin_last;
  logic [nnq_pkg::FREQ_W-1:0] query_q;

  assign accept  = start_i && !busy_q;
  assign idx_ok  = 32'(entry_index_i) < 32'(NOTE_COUNT);
  assign wr_fire = accept && (mode_i == nnq_pkg::MODE_WRITE) && idx_ok;
  assign q_fire  = accept && (mode_i == nnq_pkg::MODE_QUERY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (q_fire) begin
      busy_q <= 1'b1;
    end else if (fin_last) begin
      busy_q <= 1'b0;
    end
  end

  // hold the query for the whole item
  always_ff @(posedge clk_i) begin
    if (q_fire) begin
      query_q <= query_freq_i;
    end
  end

  assign busy_o = busy_q;

  // search chain: entry k is what cell k takes in, entry STEPS leaves the last cell
  nnq_pkg::nnq_flags_t chain_flags [STEPS+1];
  logic [IDX_W-1:0]    chain_lo    [STEPS+1];
  logic [IDX_W-1:0]    chain_hi    [STEPS+1];
  logic [IDX_W-1:0]    chain_found [STEPS+1];
  logic [IDX_W-1:0]    cell_mid    [STEPS];
  logic [STEPS-1:0]    act_v;
  logic [IDX_W-1:0]    hi0, start_mid;
  logic [nnq_pkg::FREQ_W-1:0] rdata_a_q, rdata_b_q;

  // window of the first halving: 0 .. size-2
  assign hi0       = IDX_W'(n_use - NW'(2));
  assign start_mid = hi0 >> 1;

  always_comb begin
    chain_flags[0].act  = q_fire;
    chain_flags[0].srch = q_fire;
    chain_lo[0]         = '0;
    chain_hi[0]         = hi0;
    chain_found[0]      = '0;
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_cell
    nnq_cell #(
      .IDX_W(IDX_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .flags_i (chain_flags[k]),
      .lo_i    (chain_lo[k]),
      .hi_i    (chain_hi[k]),
      .found_i (chain_found[k]),
      .query_i (query_q),
      .rdata_i (rdata_a_q),
      .flags_o (chain_flags[k+1]),
      .lo_o    (chain_lo[k+1]),
      .hi_o    (chain_hi[k+1]),
      .found_o (chain_found[k+1]),
      .mid_o   (cell_mid[k]),
      .act_o   (act_v[k])
    );
  end

  // note table, one write and two reads a cycle
  logic [nnq_pkg::FREQ_W-1:0] mem_q [NOTE_COUNT];
  logic [IDX_W-1:0]           addr_a, addr_b;

  // only one cell holds the item, so its address wins; the last cell fetches L and L+1
  always_comb begin
    addr_a = start_mid;
    for (int k = 0; k < STEPS - 1; k++) begin
      if (act_v[k]) begin
        addr_a = cell_mid[k];
      end
    end
    if (act_v[STEPS-1]) begin
      addr_a = chain_found[STEPS];
    end
    addr_b = chain_found[STEPS] + IDX_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (wr_fire) begin
      mem_q[IDX_W'(entry_index_i)] <= entry_freq_i;
    end
    rdata_a_q <= mem_q[addr_a];
    rdata_b_q <= mem_q[addr_b];
  end

  // product test against the two neighbors
  logic [IDX_W-1:0] note_idx;

  nnq_fin #(
    .IDX_W(IDX_W)
  ) u_fin (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (act_v[STEPS-1]),
    .found_i   (chain_found[STEPS]),
    .query_i   (query_q),
    .rdata_a_i (rdata_a_q),
    .rdata_b_i (rdata_b_q),
    .last_o    (fin_last),
    .done_o    (done_o),
    .note_o    (note_idx)
  );

  assign note_index_o = nnq_pkg::IDX_IN_W'(note_idx);

  // at most one cell carries the item
  a_one_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(act_v))
    else $error("more than one search cell active");

  // an idle block has nothing in the chain
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |-> (act_v == '0))
    else $error("search cell active while idle");

  // a query keeps the block busy
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_fire |=> busy_o)
    else $error("query accepted without going busy");

  // the result strobe closes the item
  a_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o && $past(busy_o))
    else $error("result strobe without a query in flight");

endmodule

// ===== rtl/nnq_cell.sv =====
module nnq_cell #(
  parameter int IDX_W = 7
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  nnq_pkg::nnq_flags_t        flags_i,
  input  logic [IDX_W-1:0]           lo_i,
  input  logic [IDX_W-1:0]           hi_i,
  input  logic [IDX_W-1:0]           found_i,
  input  logic [nnq_pkg::FREQ_W-1:0] query_i,
  input  logic [nnq_pkg::FREQ_W-1:0] rdata_i,
  output nnq_pkg::nnq_flags_t        flags_o,
  output logic [IDX_W-1:0]           lo_o,
  output logic [IDX_W-1:0]           hi_o,
  output logic [IDX_W-1:0]           found_o,
  output logic [IDX_W-1:0]           mid_o,
  output logic                       act_o
);

  nnq_pkg::nnq_flags_t flags_q;
  logic [IDX_W-1:0]    lo_q, hi_q, found_q;
  logic [IDX_W:0]      sum_in, sum_out;
  logic [IDX_W-1:0]    mid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_i;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q    <= lo_i;
    hi_q    <= hi_i;
    found_q <= found_i;
  end

  // rdata_i holds the entry at the midpoint of the held window
  assign sum_in = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid    = sum_in[IDX_W:1];

  always_comb begin
    flags_o = flags_q;
    lo_o    = lo_q;
    hi_o    = hi_q;
    found_o = found_q;
    if (flags_q.srch) begin
      if (rdata_i <= query_i) begin
        found_o = mid;
        lo_o    = mid + IDX_W'(1);
      end else if (mid == '0) begin
        flags_o.srch = 1'b0;
      end else begin
        hi_o = mid - IDX_W'(1);
      end
      if (lo_o > hi_o) begin
        flags_o.srch = 1'b0;
      end
    end
  end

  // midpoint for the next cell, issued to the table this cycle
  assign sum_out = {1'b0, lo_o} + {1'b0, hi_o};
  assign mid_o   = sum_out[IDX_W:1];
  assign act_o   = flags_q.act;

endmodule

// ===== rtl/nnq_fin.sv =====
module nnq_fin #(
  parameter int IDX_W = 7
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fire_i,
  input  logic [IDX_W-1:0]           found_i,
  input  logic [nnq_pkg::FREQ_W-1:0] query_i,
  input  logic [nnq_pkg::FREQ_W-1:0] rdata_a_i,
  input  logic [nnq_pkg::FREQ_W-1:0] rdata_b_i,
  output logic                       last_o,
  output logic                       done_o,
  output logic [IDX_W-1:0]           note_o
);

  localparam int PROD_W = 2 * nnq_pkg::FREQ_W;

  logic              v1_q, v2_q, done_q;
  logic [IDX_W-1:0]  l1_q, l2_q, note_q;
  logic [PROD_W-1:0] prod_q, sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= fire_i;
      v2_q   <= v1_q;
      done_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    l1_q   <= found_i;
    l2_q   <= l1_q;
    prod_q <= PROD_W'(rdata_a_i) * PROD_W'(rdata_b_i);
    sq_q   <= PROD_W'(query_i) * PROD_W'(query_i);
    // ties go to the upper note
    note_q <= (sq_q < prod_q) ? l2_q : l2_q + IDX_W'(1);
  end

  assign last_o = v2_q;
  assign done_o = done_q;
  assign note_o = note_q;

endmodule
